// ===== hw/rtl/cvws_pkg.sv =====
// ----------------------------------------------------------------------------
// cvws_pkg: condition-variable wait/signal unit, shared definitions
// Event and status codes, state and result records, field widths.
// ----------------------------------------------------------------------------
package cvws_pkg;

   localparam int TRAPPED_BITS = 24;
   localparam int SIG_BITS     = 24;
   localparam int SPIN_BITS    = 32;
   localparam int MULT_BITS    = 6;
   localparam int WIDE_BITS    = (TRAPPED_BITS > SIG_BITS) ? TRAPPED_BITS : SIG_BITS;

   localparam logic [SPIN_BITS-1:0] SPIN_FLOOR   = SPIN_BITS'(64);
   localparam logic [MULT_BITS-1:0] MULT_TOP     = MULT_BITS'(32);
   localparam logic [1:0]           SPINNERS_MAX = 2'd3;
   localparam logic [3:0]           FAILURES_MAX = 4'd15;
   localparam logic [SIG_BITS-1:0]  SIG_ALL      = {SIG_BITS{1'b1}};

   typedef enum logic [2:0] {
      OP_WAIT_BEGIN     = 3'd0,
      OP_SPIN_POLL      = 3'd1,
      OP_SPIN_END       = 3'd2,
      OP_TIMEOUT_CANCEL = 3'd3,
      OP_SIGNAL         = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_SIGNALED  = 3'd0,
      ST_SPIN      = 3'd1,
      ST_BLOCKED   = 3'd2,
      ST_TIMED_OUT = 3'd3,
      ST_MUST_WAIT = 3'd4,
      ST_NOT_YET   = 3'd5,
      ST_OVERFLOW  = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]              released;
      logic [1:0]              spinning;
      logic [3:0]              failures;
      logic [TRAPPED_BITS-1:0] trapped;
   } cv_state_type;

   typedef struct packed {
      status_type           status;
      logic [SPIN_BITS-1:0] spin_count;
      logic [MULT_BITS-1:0] spin_multiplier;
      logic [SIG_BITS-1:0]  signal_count;
   } cv_result_type;

endpackage

// ===== hw/rtl/cvws_event_logic.sv =====
// ----------------------------------------------------------------------------
// cvws_event_logic: one event applied to the control state
// Combinational read-modify-write: next state and result for one event.
// ----------------------------------------------------------------------------
module cvws_event_logic (
   input  logic [2:0]                       op,
   input  logic [cvws_pkg::SPIN_BITS-1:0]   max_spin,
   input  logic [cvws_pkg::SIG_BITS-1:0]    max_signal,
   input  cvws_pkg::cv_state_type           state_cur,
   output cvws_pkg::cv_state_type           state_nxt,
   output cvws_pkg::cv_result_type          result
);
   import cvws_pkg::*;

   logic [SPIN_BITS-1:0] grant;
   logic [MULT_BITS-1:0] mult;
   logic                 trapped_full;
   logic [3:0]           fail_dec;
   logic [3:0]           fail_inc;
   logic [WIDE_BITS-1:0] trapped_wide;
   logic [WIDE_BITS-1:0] limit_wide;
   logic [WIDE_BITS-1:0] released_n;

   // adaptive spin grant, shortened by past spin failures
   always_comb begin
      if (max_spin > SPIN_FLOOR) begin
         grant = (max_spin >> state_cur.failures) | SPIN_FLOOR;
         mult  = MULT_TOP >> state_cur.failures;
      end else begin
         grant = max_spin;
         mult  = '0;
      end
   end

   assign trapped_full = &state_cur.trapped;
   assign fail_dec     = (state_cur.failures != 4'd0) ? state_cur.failures - 4'd1
                                                      : state_cur.failures;
   assign fail_inc     = (state_cur.failures < FAILURES_MAX) ? state_cur.failures + 4'd1
                                                             : state_cur.failures;

   // release count for a signal: min(trapped, max_signal), all on broadcast
   assign trapped_wide = WIDE_BITS'(state_cur.trapped);
   assign limit_wide   = WIDE_BITS'(max_signal);
   assign released_n   = (max_signal != SIG_ALL && limit_wide < trapped_wide) ? limit_wide
                                                                             : trapped_wide;

   always_comb begin
      state_nxt = state_cur;
      result    = '{status: ST_NOT_YET, spin_count: '0, spin_multiplier: '0,
                    signal_count: '0};
      unique case (op)
         OP_WAIT_BEGIN: begin
            if (state_cur.released != 2'd0) begin
               state_nxt.released = state_cur.released - 2'd1;
               state_nxt.failures = fail_dec;
               result.status      = ST_SIGNALED;
            end else if (grant != '0 && state_cur.spinning < SPINNERS_MAX) begin
               state_nxt.spinning     = state_cur.spinning + 2'd1;
               result.status          = ST_SPIN;
               result.spin_count      = grant;
               result.spin_multiplier = mult;
            end else if (trapped_full) begin
               result.status = ST_OVERFLOW;
            end else begin
               state_nxt.trapped = state_cur.trapped + TRAPPED_BITS'(1);
               result.status     = ST_BLOCKED;
            end
         end
         OP_SPIN_POLL, OP_SPIN_END: begin
            if (state_cur.spinning == 2'd0) begin
               result.status = ST_NOT_YET;
            end else if (state_cur.released != 2'd0) begin
               state_nxt.spinning = state_cur.spinning - 2'd1;
               state_nxt.released = state_cur.released - 2'd1;
               state_nxt.failures = fail_dec;
               result.status      = ST_SIGNALED;
            end else if (op == OP_SPIN_POLL) begin
               result.status = ST_NOT_YET;
            end else if (trapped_full) begin
               result.status = ST_OVERFLOW;
            end else begin
               state_nxt.spinning = state_cur.spinning - 2'd1;
               state_nxt.trapped  = state_cur.trapped + TRAPPED_BITS'(1);
               state_nxt.failures = fail_inc;
               result.status      = ST_BLOCKED;
            end
         end
         OP_TIMEOUT_CANCEL: begin
            if (state_cur.trapped != '0) begin
               state_nxt.trapped = state_cur.trapped - TRAPPED_BITS'(1);
               result.status     = ST_TIMED_OUT;
            end else begin
               result.status = ST_MUST_WAIT;
            end
         end
         OP_SIGNAL: begin
            state_nxt.trapped   = TRAPPED_BITS'(trapped_wide - released_n);
            state_nxt.released  = state_cur.spinning;
            result.status       = ST_SIGNALED;
            result.signal_count = (released_n > WIDE_BITS'(SIG_ALL)) ? SIG_ALL
                                                                    : SIG_BITS'(released_n);
         end
         default: begin
            result.status = ST_NOT_YET;
         end
      endcase
   end

endmodule

// ===== hw/rtl/cond_var_wait_signal_unit.sv =====
// ----------------------------------------------------------------------------
// cond_var_wait_signal_unit: condition-variable wait/signal control unit
// The request passes the input register, then the event logic into the result register;
//   a result that is not taken holds the next event in the input register.
//   Throughput: one event per cycle while results are taken, set by the
//   read-modify-write of the packed control state.
// Reset (synchronous, active high): all counts zero, both stages empty.
// ----------------------------------------------------------------------------
module cond_var_wait_signal_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_op,
   input  logic [cvws_pkg::SPIN_BITS-1:0]      req_max_spin,
   input  logic [cvws_pkg::SIG_BITS-1:0]       req_max_signal,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_status,
   output logic [cvws_pkg::SPIN_BITS-1:0]      rsp_spin_count,
   output logic [cvws_pkg::MULT_BITS-1:0]      rsp_spin_multiplier,
   output logic [cvws_pkg::SIG_BITS-1:0]       rsp_signal_count
);
   import cvws_pkg::*;

   // input register
   logic                 in_valid_ff,   in_valid_in;
   logic [2:0]           in_op_ff;
   logic [SPIN_BITS-1:0] in_max_spin_ff;
   logic [SIG_BITS-1:0]  in_max_signal_ff;

   // control state
   cv_state_type         state_ff,      state_in;

   // result register
   logic                 out_valid_ff,  out_valid_in;
   cv_result_type        out_result_ff;

   cv_result_type        result;
   logic                 advance;
   logic                 take_req;

   // Advance the held event into the result register when that register is
   // empty or its transfer completes in this cycle; the state update rides
   // on the same edge, so back-to-back events see each other's effect.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   cvws_event_logic u_event (
      .op         (in_op_ff),
      .max_spin   (in_max_spin_ff),
      .max_signal (in_max_signal_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_in),
      .result     (result)
   );

   // hold the input stage full until its event moves on
   assign in_valid_in  = take_req || (in_valid_ff && !advance);

   // drop the result once transferred unless a new one takes its place
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_op_ff         <= req_op;
         in_max_spin_ff   <= req_max_spin;
         in_max_signal_ff <= req_max_signal;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_result_ff.status;
   assign rsp_spin_count      = out_result_ff.spin_count;
   assign rsp_spin_multiplier = out_result_ff.spin_multiplier;
   assign rsp_signal_count    = out_result_ff.signal_count;

endmodule
